### src/plc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Luma tone curve package
// Shared widths, breakpoint table, reciprocal constants and segment decode.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int unsigned NumPoints = 8;
  localparam int unsigned LumaW     = 8;
  localparam int unsigned SegW      = 3;
  localparam int unsigned DiffW     = 6;
  localparam int unsigned NumW      = 14;
  localparam int unsigned RecipW    = 15;
  localparam int unsigned RecipSh   = 20;
  localparam int unsigned ProdW     = 29;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  typedef logic [LumaW-1:0] luma_t;
  typedef luma_t [NumPoints-1:0] point_arr_t;

  localparam point_arr_t Breaks = {
    8'd255, 8'd219, 8'd182, 8'd146, 8'd109, 8'd73, 8'd36, 8'd0
  };

  localparam point_arr_t PointReset = {
    8'd255, 8'd219, 8'd182, 8'd146, 8'd109, 8'd73, 8'd36, 8'd0
  };

  // even segments are 36 wide, odd ones 37
  localparam logic [DiffW-1:0]  WidthEven = 6'd36;
  localparam logic [DiffW-1:0]  WidthOdd  = 6'd37;
  localparam logic [NumW-1:0]   BiasEven  = 14'd17;
  localparam logic [NumW-1:0]   BiasOdd   = 14'd18;
  localparam logic [RecipW-1:0] RecipEven = 15'd29128;
  localparam logic [RecipW-1:0] RecipOdd  = 15'd28340;

  function automatic logic [SegW-1:0] seg_decode(input luma_t x);
    logic [SegW-1:0] seg;
    seg = '0;
    for (int k = 1; k < NumPoints - 1; k++) begin
      if (x >= Breaks[k]) begin
        seg = SegW'(k);
      end
    end
    return seg;
  endfunction

endpackage
`default_nettype wire

### src/piecewise_linear_luma_curve_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Piecewise linear luma curve
// Maps 8-bit luma through an eight-point tone curve with APB level registers.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy never rises, so
// one sample per clock is sustained. Each request gives exactly one result,
// strobed on out_valid_o for one cycle, registered through the five-stage
// arithmetic pipeline (decode, products, sum, reciprocal multiply, saturate).
// The receiver cannot stall the output.
// Levels are written through the APB port at byte address 4*i for point i.
// ----------------------------------------------------------------------------
module piecewise_linear_luma_curve_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire plc_pkg::luma_t              luma_in_i,
  output logic                             out_valid_o,
  output plc_pkg::luma_t                   luma_out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [plc_pkg::AddrW-1:0]   paddr,
  input  wire logic [plc_pkg::DataW-1:0]   pwdata,
  output logic [plc_pkg::DataW-1:0]        prdata,
  output logic                             pready
);
  import plc_pkg::*;

  point_arr_t      points_q;
  logic [SegW-1:0] reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= PointReset;
    end else if (wr_en) begin
      points_q[reg_idx] <= pwdata[LumaW-1:0];
    end
  end

  assign prdata = {{(DataW-LumaW){1'b0}}, points_q[reg_idx]};
  assign pready = 1'b1;
  assign busy   = 1'b0;

  plc_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start),
    .luma_i   (luma_in_i),
    .points_i (points_q),
    .valid_o  (out_valid_o),
    .luma_o   (luma_out_o)
  );

endmodule
`default_nettype wire

### src/plc_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Luma tone curve pipeline
// Five register stages: decode, weight products, biased sum, reciprocal
// multiply, saturate.
// ----------------------------------------------------------------------------
module plc_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire plc_pkg::luma_t     luma_i,
  input  wire plc_pkg::point_arr_t points_i,
  output logic                    valid_o,
  output plc_pkg::luma_t          luma_o
);
  import plc_pkg::*;

  logic [SegW-1:0]  seg;
  luma_t            offs;
  logic [DiffW-1:0] wid;

  logic             s1_valid_q;
  logic [DiffW-1:0] s1_d_q, s1_span_q;
  luma_t            s1_lo_q, s1_hi_q;
  logic             s1_odd_q;

  logic             s2_valid_q;
  logic [NumW-1:0]  s2_m0_q, s2_m1_q;
  logic             s2_odd_q;

  logic             s3_valid_q;
  logic [NumW-1:0]  s3_num_q;
  logic             s3_odd_q;

  logic             s4_valid_q;
  logic [ProdW-1:0] s4_prod_q;

  logic [LumaW:0]   quot;
  logic             out_valid_q;
  luma_t            out_luma_q;

  assign seg  = seg_decode(luma_i);
  assign offs = luma_i - Breaks[seg];
  assign wid  = seg[0] ? WidthOdd : WidthEven;
  assign quot = s4_prod_q[ProdW-1:RecipSh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_d_q    <= offs[DiffW-1:0];
    s1_span_q <= wid - offs[DiffW-1:0];
    s1_lo_q   <= points_i[seg];
    s1_hi_q   <= points_i[seg + SegW'(1)];
    s1_odd_q  <= seg[0];

    s2_m0_q  <= NumW'(s1_lo_q) * NumW'(s1_span_q);
    s2_m1_q  <= NumW'(s1_hi_q) * NumW'(s1_d_q);
    s2_odd_q <= s1_odd_q;

    s3_num_q <= s2_m0_q + s2_m1_q + (s2_odd_q ? BiasOdd : BiasEven);
    s3_odd_q <= s2_odd_q;

    s4_prod_q <= ProdW'(s3_num_q) * ProdW'(s3_odd_q ? RecipOdd : RecipEven);

    out_luma_q <= quot[LumaW] ? {LumaW{1'b1}} : quot[LumaW-1:0];
  end

  assign valid_o = out_valid_q;
  assign luma_o  = out_luma_q;

endmodule
`default_nettype wire
